// ----- hdl/command_frame_checker_macros.svh -----
// ---------------------------------------------------------------------------
// command_frame_checker assertion macros
// Shared concurrent assertion forms, clocked on clock, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef COMMAND_FRAME_CHECKER_MACROS_SVH
`define COMMAND_FRAME_CHECKER_MACROS_SVH

// property holds in the same cycle
`define CFC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/cfc_pkg.sv -----
// ---------------------------------------------------------------------------
// cfc_pkg
// Types and constants shared by the command frame checker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

   // result status codes
   localparam logic [1:0] STATUS_VALID    = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [1:0] STATUS_FORMAT   = 2'd2;

   // frame markers
   localparam logic [7:0] SYNC_HI  = 8'hFF;
   localparam logic [7:0] SYNC_LO  = 8'h55;
   localparam logic [7:0] TAIL_HI  = 8'hFF;
   localparam logic [7:0] TAIL_LO  = 8'hAA;

   localparam logic [7:0] MIN_LEN       = 8'd4;
   localparam logic [7:0] PAYLOAD_START = 8'd5;
   localparam logic [4:0] RESULT_LIMIT  = 5'd23;

   // controller -> datapath
   typedef struct packed {
      logic byte_we;       // accepted input word
      logic clear;         // restart frame collection
      logic load_single;   // load the one-word result of an evaluation
      logic rd_en;         // read payload byte at current index
      logic load_payload;  // load a payload result
      logic idx_inc;       // step payload index
   } cfc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;      // output register can take a word this cycle
      logic single;        // evaluation yields exactly one result
      logic emit_last;     // current payload index is the final one
   } cfc_stat_type;

endpackage

`default_nettype wire

// ----- hdl/command_frame_checker.sv -----
// ---------------------------------------------------------------------------
// command_frame_checker
// Length-prefixed command frame checker with additive checksum.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: one received byte per word; req_tlast marks the last byte
//    of the buffer. Bytes are taken one per cycle while collecting.
//  - After the last byte the input closes (req_tready low) while the frame
//    is judged. Format or checksum errors give one rsp word; a good frame
//    gives one word per payload byte (at most 23), or a single word with
//    no payload. rsp_tlast marks the final word of the frame.
//  - Timing: a single result is loaded in the evaluation step once the
//    output register is free. Each payload result takes a store read, then
//    an output load (the next read waits for that load), set by the one
//    registered read port of the frame store.
//  - req_tready returns once the final result is loaded, so a new buffer
//    can stream in while that word still waits on rsp.
//  - Reset (synchronous) empties the buffer and the output register; the
//    store contents are not cleared and never read before being written.
//  - A stalled receiver holds the output word; evaluation and the payload
//    walk wait until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module command_frame_checker #(
   parameter int MAX_FRAME_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tlast,   // end_of_buffer

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] command_type, [23:16] payload_byte,
                                         // [28:24] payload_index, [31:29] zero
   output logic [2:0]       rsp_tuser,   // [1:0] status, [2] has_payload
   output logic             rsp_tlast    // last
);

   cfc_pkg::cfc_cmd_type  cmd;
   cfc_pkg::cfc_stat_type stat;

   logic [1:0]  rsp_status;
   logic [15:0] rsp_command_type;
   logic [7:0]  rsp_payload_byte;
   logic [4:0]  rsp_payload_index;
   logic        rsp_has_payload;

   cfc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cfc_datapath #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .rx_byte           (req_tdata),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_status        (rsp_status),
      .rsp_command_type  (rsp_command_type),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_has_payload   (rsp_has_payload),
      .rsp_last          (rsp_tlast)
   );

   // word packing, highest field first
   assign rsp_tdata = {3'b000, rsp_payload_index, rsp_payload_byte, rsp_command_type};
   assign rsp_tuser = {rsp_has_payload, rsp_status};

endmodule

`default_nettype wire

// ----- hdl/cfc_datapath.sv -----
// ---------------------------------------------------------------------------
// cfc_datapath
// Frame store, header/tail capture, running checksum and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "command_frame_checker_macros.svh"

module cfc_datapath #(
   parameter int MAX_FRAME_BYTES = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         rx_byte,
   input  wire cfc_pkg::cfc_cmd_type cmd,
   output cfc_pkg::cfc_stat_type   stat,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_command_type,
   output logic [7:0]              rsp_payload_byte,
   output logic [4:0]              rsp_payload_index,
   output logic                    rsp_has_payload,
   output logic                    rsp_last
);

   localparam int AW = $clog2(MAX_FRAME_BYTES);
   localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [8:0] MAX9 = 9'(MAX_FRAME_BYTES);

   logic [7:0] mem [MAX_FRAME_BYTES];
   logic [7:0] rd_data_ff;

   logic [PW-1:0] pos_ff, pos_in;
   logic          ovf_ff, ovf_in;
   logic [15:0]   sum_ff, sum_in;
   logic [7:0]    b0_ff, b1_ff, len_ff, typ_hi_ff, typ_lo_ff;
   logic [7:0]    ck_hi_ff, ck_lo_ff, tl_hi_ff, tl_lo_ff;
   logic [4:0]    idx_ff, idx_in;

   logic          out_vld_ff, out_vld_in;
   logic [1:0]    o_status_ff;
   logic [15:0]   o_type_ff;
   logic [7:0]    o_byte_ff;
   logic [4:0]    o_idx_ff;
   logic          o_has_ff, o_last_ff;

   logic [8:0]    pos9, len9;
   logic          store_en;
   logic          fmt_bad, ck_bad;
   logic [1:0]    frame_status;
   logic [7:0]    len_m5;
   logic [4:0]    count;
   logic [5:0]    rd_addr6;
   logic [15:0]   frame_type;

   assign pos9     = 9'(pos_ff);
   assign len9     = 9'(len_ff);
   assign store_en = cmd.byte_we && (pos9 < MAX9);

   // ---- frame collection ----
   always_comb begin
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      sum_in = sum_ff;
      if (cmd.clear) begin
         pos_in = '0;
         ovf_in = 1'b0;
         sum_in = '0;
      end else if (store_en) begin
         pos_in = pos_ff + PW'(1);
         if (pos9 == 9'd2 || (pos9 >= 9'd3 && pos9 < len9))
            sum_in = sum_ff + 16'(rx_byte);
      end else if (cmd.byte_we) begin
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ovf_ff <= 1'b0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
         sum_ff <= sum_in;
      end
   end

   // header and tail bytes are captured as they pass
   always_ff @(posedge clock) begin
      if (store_en) begin
         if (pos9 == 9'd0) b0_ff     <= rx_byte;
         if (pos9 == 9'd1) b1_ff     <= rx_byte;
         if (pos9 == 9'd2) len_ff    <= rx_byte;
         if (pos9 == 9'd3) typ_hi_ff <= rx_byte;
         if (pos9 == 9'd4) typ_lo_ff <= rx_byte;
         if (pos9 >= 9'd3 && pos9 == len9)          ck_hi_ff <= rx_byte;
         if (pos9 >= 9'd3 && pos9 == len9 + 9'd1)   ck_lo_ff <= rx_byte;
         if (pos9 >= 9'd3 && pos9 == len9 + 9'd2)   tl_hi_ff <= rx_byte;
         if (pos9 >= 9'd3 && pos9 == len9 + 9'd3)   tl_lo_ff <= rx_byte;
      end
   end

   // ---- frame store ----
   assign rd_addr6 = 6'(idx_ff) + 6'(cfc_pkg::PAYLOAD_START);

   always_ff @(posedge clock) begin
      if (store_en)
         mem[pos_ff[AW-1:0]] <= rx_byte;
      if (cmd.rd_en)
         rd_data_ff <= mem[rd_addr6[AW-1:0]];
   end

   // ---- evaluation ----
   assign fmt_bad = ovf_ff || (pos9 < 9'd3) || (len_ff < cfc_pkg::MIN_LEN)
                 || (len9 + 9'd4 > MAX9) || (pos9 < len9 + 9'd4)
                 || (b0_ff != cfc_pkg::SYNC_HI) || (b1_ff != cfc_pkg::SYNC_LO)
                 || (tl_hi_ff != cfc_pkg::TAIL_HI) || (tl_lo_ff != cfc_pkg::TAIL_LO);
   assign ck_bad  = (sum_ff != {ck_hi_ff, ck_lo_ff});

   always_comb begin
      priority if (fmt_bad) frame_status = cfc_pkg::STATUS_FORMAT;
      else if (ck_bad)      frame_status = cfc_pkg::STATUS_CHECKSUM;
      else                  frame_status = cfc_pkg::STATUS_VALID;
   end

   assign len_m5 = len_ff - cfc_pkg::PAYLOAD_START;

   always_comb begin
      priority if (len_ff <= cfc_pkg::PAYLOAD_START)     count = '0;
      else if (len_m5 > 8'(cfc_pkg::RESULT_LIMIT))       count = cfc_pkg::RESULT_LIMIT;
      else                                               count = len_m5[4:0];
   end

   assign frame_type = {typ_hi_ff, typ_lo_ff};

   // ---- payload index ----
   always_comb begin
      idx_in = idx_ff;
      if (cmd.clear)        idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else       idx_ff <= idx_in;
   end

   // ---- output register ----
   assign stat.out_free  = !out_vld_ff || rsp_tready;
   assign stat.single    = (frame_status != cfc_pkg::STATUS_VALID) || (count == '0);
   assign stat.emit_last = (idx_ff + 5'd1 == count);

   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.load_single || cmd.load_payload) out_vld_in = 1'b1;
      else if (rsp_tready)                     out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= out_vld_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_single) begin
         o_status_ff <= frame_status;
         o_type_ff   <= (frame_status == cfc_pkg::STATUS_VALID) ? frame_type : 16'd0;
         o_byte_ff   <= '0;
         o_idx_ff    <= '0;
         o_has_ff    <= 1'b0;
         o_last_ff   <= 1'b1;
      end else if (cmd.load_payload) begin
         o_status_ff <= cfc_pkg::STATUS_VALID;
         o_type_ff   <= frame_type;
         o_byte_ff   <= rd_data_ff;
         o_idx_ff    <= idx_ff;
         o_has_ff    <= 1'b1;
         o_last_ff   <= stat.emit_last;
      end
   end

   assign rsp_tvalid        = out_vld_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_command_type  = o_type_ff;
   assign rsp_payload_byte  = o_byte_ff;
   assign rsp_payload_index = o_idx_ff;
   assign rsp_has_payload   = o_has_ff;
   assign rsp_last          = o_last_ff;

   // ---- checks ----
   `CFC_ASSERT(a_load_into_free, (!(cmd.load_single || cmd.load_payload)) || stat.out_free, "result loaded over a pending word")
   `CFC_ASSERT(a_nonlast_is_payload, (!(out_vld_ff && !o_last_ff)) || o_has_ff, "non-final result without payload")
   `CFC_ASSERT(a_ovf_only_when_full, (!ovf_ff) || (pos9 == MAX9), "overflow flagged before store full")

endmodule

`default_nettype wire

// ----- hdl/cfc_controller.sv -----
// ---------------------------------------------------------------------------
// cfc_controller
// Sequencer: byte collection, evaluation, payload walk through the store.
// ---------------------------------------------------------------------------
`default_nettype none
`include "command_frame_checker_macros.svh"

module cfc_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tlast,
   output logic                       req_tready,
   input  wire cfc_pkg::cfc_stat_type stat,
   output cfc_pkg::cfc_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,   // collecting bytes
      S_EVAL = 4'b0010,   // decide status
      S_RD   = 4'b0100,   // store read of one payload byte
      S_OUT  = 4'b1000    // hand payload byte to output register
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.byte_we = req_tvalid;
            if (req_tvalid && req_tlast) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!stat.single) begin
               cmd.clear = 1'b1;
               state_in  = S_RD;
            end else if (stat.out_free) begin
               cmd.load_single = 1'b1;
               cmd.clear       = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.load_payload = 1'b1;
               if (stat.emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // ---- checks ----
   `CFC_ASSERT_NEXT(a_last_to_eval, req_tvalid && req_tready && req_tlast, (state_ff == S_EVAL) && !req_tready, "end of buffer did not start evaluation")
   `CFC_ASSERT_NEXT(a_read_then_out, state_ff == S_RD, state_ff == S_OUT, "store read not followed by output step")
   `CFC_ASSERT(a_ready_falls_on_last, (!$fell(req_tready)) || $past(req_tvalid && req_tlast), "input closed without end of buffer")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// command_frame_checker testbench
// Streams receive buffers into the frame checker and scores every rsp word
// against a local frame judge. Directed buffers go first: a lone byte, a bad
// length, a checksum error and a good frame with payload extremes and a
// trailing byte. Random buffers follow: mostly well-formed frames, then
// corrupted, truncated, overrun and noise buffers. Traffic runs through four
// flow-control phases.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FRAME_BYTES = 32;
   localparam int RANDOM_WORDS    = 396;
   localparam int DRAIN_CYCLES    = 40;

   // one expected or observed rsp word
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] command_type;
      logic [7:0]  payload_byte;
      logic [4:0]  payload_index;
      logic        has_payload;
      logic        last;
   } frame_result_type;

   // directed stimulus row; fixed_check rows carry a hand-typed status
   typedef struct packed {
      logic [7:0] rx_b;
      logic       eob;
      logic       fixed_check;
      logic [1:0] fixed_status;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [7:0] rx_byte
   logic        req_tlast  = 1'b0;  // end_of_buffer

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [15:0] command_type, [23:16] payload_byte,
                                    // [28:24] payload_index, [31:29] zero
   logic [2:0]  rsp_tuser;          // [1:0] status, [2] has_payload
   logic        rsp_tlast;          // last

   // frame judge state: mirror of the buffer being collected
   logic [7:0]  rx_store [MAX_FRAME_BYTES];
   int          rx_count   = 0;
   bit          rx_overrun = 1'b0;

   frame_result_type awaited_results [$];
   logic [7:0]       frame_bytes [$];

   int error_count  = 0;
   int idle_pct     = 0;   // sender gap chance per cycle
   int stall_pct    = 0;   // receiver stall chance per cycle
   int random_bytes = 0;

   // Directed buffers. Error rows are typed in; the good frame is left to
   // the judge (type FFFF, payload 00 then FF, one byte past the tail).
   stim_row_type directed_rows [24] = '{
      // lone byte: short buffer
      '{8'hFF, 1'b1, 1'b1, cfc_pkg::STATUS_FORMAT},
      // length 3 is below the minimum
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h55, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h03, 1'b1, 1'b1, cfc_pkg::STATUS_FORMAT},
      // length 4, sum is 0004 but 0005 is sent
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h55, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h04, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h00, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h00, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h05, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'hAA, 1'b1, 1'b1, cfc_pkg::STATUS_CHECKSUM},
      // length 7, sum 0304, extra byte after the tail
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h55, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h07, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h00, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h03, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h04, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'hFF, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'hAA, 1'b0, 1'b0, cfc_pkg::STATUS_VALID},
      '{8'h5A, 1'b1, 1'b0, cfc_pkg::STATUS_VALID}
   };

   command_frame_checker #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop, far above the slowest legal run
   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Frame judge: stores one accepted byte; on the end mark judges the
   // buffer and queues the expected rsp words (when predict is set).
   function automatic void absorb_byte(input logic [7:0] rx_b, input logic eob,
                                       input bit predict);
      int               len;
      int               count;
      logic [15:0]      sum;
      frame_result_type r;
      if (rx_count < MAX_FRAME_BYTES) begin
         rx_store[rx_count] = rx_b;
         rx_count++;
      end else begin
         rx_overrun = 1'b1;
      end
      if (!eob) return;

      r        = '0;
      r.last   = 1'b1;
      r.status = cfc_pkg::STATUS_FORMAT;
      count    = 0;
      len      = (rx_count >= 3) ? int'(rx_store[2]) : 0;
      // short-circuit keeps every read inside the bytes of this buffer
      if (!rx_overrun && rx_count >= 3 && len >= cfc_pkg::MIN_LEN &&
          len + 4 <= MAX_FRAME_BYTES && rx_count >= len + 4 &&
          rx_store[0] == cfc_pkg::SYNC_HI && rx_store[1] == cfc_pkg::SYNC_LO &&
          rx_store[len + 2] == cfc_pkg::TAIL_HI &&
          rx_store[len + 3] == cfc_pkg::TAIL_LO) begin
         sum = '0;
         for (int i = 2; i < len; i++) sum += rx_store[i];
         if (sum != {rx_store[len], rx_store[len + 1]}) begin
            r.status = cfc_pkg::STATUS_CHECKSUM;
         end else begin
            r.status       = cfc_pkg::STATUS_VALID;
            r.command_type = {rx_store[3], rx_store[4]};
            count          = (len > cfc_pkg::PAYLOAD_START)
                             ? len - cfc_pkg::PAYLOAD_START : 0;
            if (count > cfc_pkg::RESULT_LIMIT) count = cfc_pkg::RESULT_LIMIT;
         end
      end

      if (predict) begin
         if (count == 0) begin
            awaited_results.push_back(r);
         end else begin
            for (int i = 0; i < count; i++) begin
               r.has_payload   = 1'b1;
               r.payload_byte  = rx_store[cfc_pkg::PAYLOAD_START + i];
               r.payload_index = i[4:0];
               r.last          = (i + 1 == count);
               awaited_results.push_back(r);
            end
         end
      end
      rx_count   = 0;
      rx_overrun = 1'b0;
   endfunction

   // byte with a bias toward the extremes
   function automatic logic [7:0] pick_byte();
      unique case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Puts one word on req, with random sender gaps ahead of it. Called at a
   // falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [7:0] rx_b, input logic eob);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx_b;
      req_tlast  <= eob;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Random buffer: mostly well-formed frames, the rest broken on purpose.
   task automatic build_frame();
      int          kind;
      int          len;
      int          k;
      logic [15:0] sum;
      frame_bytes.delete();
      kind = $urandom_range(99);

      if (kind >= 90) begin
         // overrun (90..94) or plain noise (95..99)
         k = (kind < 95) ? $urandom_range(MAX_FRAME_BYTES + 1, MAX_FRAME_BYTES + 8)
                         : $urandom_range(1, 6);
         if (kind < 95) begin
            frame_bytes.push_back(cfc_pkg::SYNC_HI);
            frame_bytes.push_back(cfc_pkg::SYNC_LO);
         end
         while (frame_bytes.size() < k) frame_bytes.push_back(pick_byte());
         return;
      end

      // well-formed base frame; the longest length shows up now and then
      len = ($urandom_range(9) == 0) ? MAX_FRAME_BYTES - 4 : $urandom_range(4, 12);
      frame_bytes.push_back(cfc_pkg::SYNC_HI);
      frame_bytes.push_back(cfc_pkg::SYNC_LO);
      frame_bytes.push_back(8'(len));
      sum = 16'(len);
      for (int i = 3; i < len; i++) begin
         frame_bytes.push_back(pick_byte());
         sum += frame_bytes[i];
      end
      frame_bytes.push_back(sum[15:8]);
      frame_bytes.push_back(sum[7:0]);
      frame_bytes.push_back(cfc_pkg::TAIL_HI);
      frame_bytes.push_back(cfc_pkg::TAIL_LO);
      if ($urandom_range(4) == 0) begin
         k = $urandom_range(1, 3);
         repeat (k) frame_bytes.push_back(pick_byte());
      end

      if (kind >= 86) begin
         // truncated somewhere in the frame
         k = $urandom_range(1, frame_bytes.size() - 1);
         repeat (k) void'(frame_bytes.pop_back());
      end else if (kind >= 82) begin
         // length out of range: below the minimum or past the store
         frame_bytes[2] = $urandom_range(1)
                          ? 8'($urandom_range(cfc_pkg::MIN_LEN - 1))
                          : 8'($urandom_range(MAX_FRAME_BYTES - 3, 255));
      end else if (kind >= 77) begin
         k = len + 2 + $urandom_range(1);
         frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
      end else if (kind >= 72) begin
         k = $urandom_range(1);
         frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
      end else if (kind >= 65) begin
         // one checksum bit flipped
         k = len + $urandom_range(1);
         frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(7));
      end
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // rsp scoreboard: each accepted word against the oldest expectation
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status        = rsp_tuser[1:0];
         got.has_payload   = rsp_tuser[2];
         got.command_type  = rsp_tdata[15:0];
         got.payload_byte  = rsp_tdata[23:16];
         got.payload_index = rsp_tdata[28:24];
         got.last          = rsp_tlast;
         if (awaited_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected rsp word, expected none, got %h", $time, got);
         end else begin
            want = awaited_results.pop_front();
            if (got != want || rsp_tdata[31:29] != 3'b000) begin
               error_count++;
               if (got.status != want.status)
                  $display("%0t: status expected %0d got %0d", $time,
                           want.status, got.status);
               if (got.command_type != want.command_type)
                  $display("%0t: command_type expected %h got %h", $time,
                           want.command_type, got.command_type);
               if (got.payload_byte != want.payload_byte)
                  $display("%0t: payload_byte expected %h got %h", $time,
                           want.payload_byte, got.payload_byte);
               if (got.payload_index != want.payload_index)
                  $display("%0t: payload_index expected %0d got %0d", $time,
                           want.payload_index, got.payload_index);
               if (got.has_payload != want.has_payload)
                  $display("%0t: has_payload expected %0d got %0d", $time,
                           want.has_payload, got.has_payload);
               if (got.last != want.last)
                  $display("%0t: last expected %0d got %0d", $time,
                           want.last, got.last);
               if (rsp_tdata[31:29] != 3'b000)
                  $display("%0t: tdata pad expected 0 got %0d", $time,
                           rsp_tdata[31:29]);
            end
         end
      end
   end

   // main sequence
   initial begin
      frame_result_type fixed;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, no flow-control pressure
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].rx_b, directed_rows[i].eob);
         absorb_byte(directed_rows[i].rx_b, directed_rows[i].eob,
                     !directed_rows[i].fixed_check);
         if (directed_rows[i].fixed_check && directed_rows[i].eob) begin
            fixed        = '0;
            fixed.status = directed_rows[i].fixed_status;
            fixed.last   = 1'b1;
            awaited_results.push_back(fixed);
         end
      end

      // random part, phases: free flow, sender gaps, receiver stalls, both
      while (random_bytes < RANDOM_WORDS) begin
         unique case (random_bytes * 4 / RANDOM_WORDS)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         build_frame();
         foreach (frame_bytes[i]) begin
            send_word(frame_bytes[i], i == frame_bytes.size() - 1);
            absorb_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b1);
         end
         random_bytes += frame_bytes.size();
      end
      req_tvalid <= 1'b0;

      // drain, then a quiet tail to catch stray words
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/cfc_pkg.sv
hdl/cfc_datapath.sv
hdl/cfc_controller.sv
hdl/command_frame_checker.sv
tb/testbench.sv
